// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset only
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mipsdec_pkg.sv -----
`timescale 1ns / 1ps

package mipsdec_pkg;

    // Instruction formats
    typedef enum logic [1:0] {
        FMT_R   = 2'd0,
        FMT_I   = 2'd1,
        FMT_J   = 2'd2,
        FMT_BAD = 2'd3
    } t_format;

    // Dense operation ids: R ops, then I ops, then the two jumps
    typedef enum logic [5:0] {
        OPID_ADD, OPID_ADDU, OPID_AND, OPID_DIV, OPID_DIVU, OPID_JALR, OPID_JR,
        OPID_MFHI, OPID_MFLO, OPID_MTHI, OPID_MTLO, OPID_MULT, OPID_MULTU,
        OPID_NOR, OPID_OR, OPID_SLL, OPID_SLLV, OPID_SLT, OPID_SLTU, OPID_SRA,
        OPID_SRAV, OPID_SRL, OPID_SRLV, OPID_SUB, OPID_SUBU, OPID_SYSCALL,
        OPID_XOR, OPID_BREAK,
        OPID_ADDI, OPID_ADDIU, OPID_ANDI, OPID_BEQ, OPID_BGTZ, OPID_BLEZ,
        OPID_BNE, OPID_LBU, OPID_LHU, OPID_LL, OPID_LUI, OPID_LW, OPID_LWL,
        OPID_LWR, OPID_ORI, OPID_SB, OPID_SC, OPID_SH, OPID_SLTI, OPID_SLTIU,
        OPID_SW, OPID_XORI,
        OPID_J, OPID_JAL
    } t_op_id;

    localparam t_op_id OPID_R_LAST = OPID_BREAK;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // Function codes of the R format
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    typedef struct packed {
        logic   hit;
        t_op_id id;
    } t_lookup;

    typedef struct packed {
        t_format     format;
        logic        recognised;
        t_op_id      op_id;
        logic [5:0]  opcode;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  shamt;
        logic [5:0]  funct;
        logic [15:0] imm;
        logic [25:0] target;
    } t_item;

    function automatic t_lookup r_lookup(logic [5:0] fn);
        t_lookup l;
        l.hit = 1'b1;
        case (fn)
            FN_ADD:     l.id = OPID_ADD;
            FN_ADDU:    l.id = OPID_ADDU;
            FN_AND:     l.id = OPID_AND;
            FN_DIV:     l.id = OPID_DIV;
            FN_DIVU:    l.id = OPID_DIVU;
            FN_JALR:    l.id = OPID_JALR;
            FN_JR:      l.id = OPID_JR;
            FN_MFHI:    l.id = OPID_MFHI;
            FN_MFLO:    l.id = OPID_MFLO;
            FN_MTHI:    l.id = OPID_MTHI;
            FN_MTLO:    l.id = OPID_MTLO;
            FN_MULT:    l.id = OPID_MULT;
            FN_MULTU:   l.id = OPID_MULTU;
            FN_NOR:     l.id = OPID_NOR;
            FN_OR:      l.id = OPID_OR;
            FN_SLL:     l.id = OPID_SLL;
            FN_SLLV:    l.id = OPID_SLLV;
            FN_SLT:     l.id = OPID_SLT;
            FN_SLTU:    l.id = OPID_SLTU;
            FN_SRA:     l.id = OPID_SRA;
            FN_SRAV:    l.id = OPID_SRAV;
            FN_SRL:     l.id = OPID_SRL;
            FN_SRLV:    l.id = OPID_SRLV;
            FN_SUB:     l.id = OPID_SUB;
            FN_SUBU:    l.id = OPID_SUBU;
            FN_SYSCALL: l.id = OPID_SYSCALL;
            FN_XOR:     l.id = OPID_XOR;
            FN_BREAK:   l.id = OPID_BREAK;
            default: begin
                l.hit = 1'b0;
                l.id  = OPID_ADD;
            end
        endcase
        return l;
    endfunction

    // Only reached for I-format opcodes; LB and LH have no id
    function automatic t_lookup i_lookup(logic [5:0] op);
        t_lookup l;
        l.hit = 1'b1;
        case (op)
            OP_ADDI:  l.id = OPID_ADDI;
            OP_ADDIU: l.id = OPID_ADDIU;
            OP_ANDI:  l.id = OPID_ANDI;
            OP_BEQ:   l.id = OPID_BEQ;
            OP_BGTZ:  l.id = OPID_BGTZ;
            OP_BLEZ:  l.id = OPID_BLEZ;
            OP_BNE:   l.id = OPID_BNE;
            OP_LBU:   l.id = OPID_LBU;
            OP_LHU:   l.id = OPID_LHU;
            OP_LUI:   l.id = OPID_LUI;
            OP_LW:    l.id = OPID_LW;
            OP_ORI:   l.id = OPID_ORI;
            OP_SB:    l.id = OPID_SB;
            OP_SH:    l.id = OPID_SH;
            OP_SLTI:  l.id = OPID_SLTI;
            OP_SLTIU: l.id = OPID_SLTIU;
            OP_SW:    l.id = OPID_SW;
            OP_XORI:  l.id = OPID_XORI;
            default: begin
                l.hit = 1'b0;
                l.id  = OPID_ADD;
            end
        endcase
        return l;
    endfunction

    function automatic t_item decode(logic [31:0] w);
        t_item      d;
        t_lookup    l;
        logic [5:0] op;
        op           = w[31:26];
        d            = '0;
        d.format     = FMT_BAD;
        d.recognised = 1'b0;
        d.op_id      = OPID_ADD;
        d.opcode     = op;
        case (op)
            OP_SPECIAL, OP_COP0, OP_COP1, OP_COP2: begin
                l            = r_lookup(w[5:0]);
                d.format     = FMT_R;
                d.rs         = w[25:21];
                d.rt         = w[20:16];
                d.rd         = w[15:11];
                d.shamt      = w[10:6];
                d.funct      = w[5:0];
                d.recognised = l.hit;
                d.op_id      = l.id;
            end
            OP_J, OP_JAL: begin
                d.format     = FMT_J;
                d.target     = w[25:0];
                d.recognised = 1'b1;
                d.op_id      = (op == OP_J) ? OPID_J : OPID_JAL;
            end
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI,
            OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW,
            OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
                l            = i_lookup(op);
                d.format     = FMT_I;
                d.rs         = w[25:21];
                d.rt         = w[20:16];
                d.imm        = w[15:0];
                d.recognised = l.hit;
                d.op_id      = l.id;
            end
            default: ;
        endcase
        return d;
    endfunction

endpackage

// ----- src/mips_instruction_decoder.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// MIPS32 instruction decoder.
// Input: raise start with the instruction word on i_instruction_word; the
//   item is taken at the clock edge where start is high and busy is low.
//   busy never rises, so one word may be taken on every clock.
// Output: one decoded item per word, on the o_ result ports for exactly one
//   cycle, marked by o_strobe. Format, dense operation id, recognised flag,
//   opcode, and the rs/rt/rd/shamt/funct/immediate/target fields; fields the
//   format does not use read as zero. Unknown opcodes give format invalid.
// Pipeline: a taken word passes two registers (input word, decoded item)
//   before its result is shown. Throughput: one item per clock, set by the
//   single decode stage between the two registers.
// Reset: synchronous, active low; clears the valid flags so no strobe is
//   given for words in flight. Payload registers are not reset.
// The receiver cannot stall: every result is taken in its strobe cycle.
module mips_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_instruction_word,
    output logic        busy,
    output logic        o_strobe,
    output logic [1:0]  o_format,
    output logic        o_recognised,
    output logic [5:0]  o_operation_id,
    output logic [5:0]  o_opcode,
    output logic [4:0]  o_source_reg,
    output logic [4:0]  o_target_reg,
    output logic [4:0]  o_dest_reg,
    output logic [4:0]  o_shift_amount,
    output logic [5:0]  o_function_code,
    output logic [15:0] o_immediate,
    output logic [25:0] o_jump_target
);

    // Input stage
    logic                 r_in_vld;
    logic [31:0]          r_word;
    // Result stage
    logic                 r_out_vld;
    mipsdec_pkg::t_item   r_item;
    mipsdec_pkg::t_item   n_item;

    // Decoding is a flat table lookup: always ready for the next word
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_word <= i_instruction_word;
        end
        r_item <= n_item;
    end

    // Field split, format select and op-id lookup
    always_comb begin
        n_item = mipsdec_pkg::decode(r_word);
    end

    assign o_strobe        = r_out_vld;
    assign o_format        = r_item.format;
    assign o_recognised    = r_item.recognised;
    assign o_operation_id  = r_item.op_id;
    assign o_opcode        = r_item.opcode;
    assign o_source_reg    = r_item.rs;
    assign o_target_reg    = r_item.rt;
    assign o_dest_reg      = r_item.rd;
    assign o_shift_amount  = r_item.shamt;
    assign o_function_code = r_item.funct;
    assign o_immediate     = r_item.imm;
    assign o_jump_target   = r_item.target;

    // Every word in the input stage produces exactly one strobe next cycle
    `ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, r_in_vld, o_strobe, "item lost")
    `ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !r_in_vld, !o_strobe, "item invented")
    // Invalid opcode: nothing but the opcode is given
    `ASSERT_NOW(a_bad_fields, i_clk, i_rst_n,
        o_strobe && o_format == mipsdec_pkg::FMT_BAD,
        !o_recognised && o_operation_id == 6'd0 && o_source_reg == 5'd0 &&
        o_immediate == 16'd0 && o_jump_target == 26'd0, "invalid opcode leaks fields")
    // J format: register and immediate fields stay clear, always recognised
    `ASSERT_NOW(a_j_fields, i_clk, i_rst_n,
        o_strobe && o_format == mipsdec_pkg::FMT_J,
        o_recognised && o_source_reg == 5'd0 && o_target_reg == 5'd0 &&
        o_immediate == 16'd0 && o_function_code == 6'd0, "jump item malformed")
    // R format ids stay within the R range, and R items carry no immediate
    `ASSERT_NOW(a_r_id_range, i_clk, i_rst_n,
        o_strobe && o_format == mipsdec_pkg::FMT_R,
        o_operation_id <= mipsdec_pkg::OPID_R_LAST && o_immediate == 16'd0,
        "R item outside R id range")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mipsdec_pkg::*;

    // Decoded item as the block gives it on its result ports
    typedef struct packed {
        t_format     fmt;
        logic        rec;
        t_op_id      op_id;
        logic [5:0]  opcode;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [5:0]  fn;
        logic [15:0] imm;
        logic [25:0] tgt;
    } decoded_t;

    // One row of the directed table; a typed decode is used only where has_typed is set
    typedef struct {
        logic [31:0] word;
        bit          has_typed;
        decoded_t    typed;
    } row_t;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no word accepted and no result
    localparam int RANDOM_ITEMS   = 700;
    localparam int DRAIN_CYCLES   = 10;     // two register stages, plus margin

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_instruction_word = '0;
    logic        busy;
    logic        o_strobe;
    logic [1:0]  o_format;
    logic        o_recognised;
    logic [5:0]  o_operation_id;
    logic [5:0]  o_opcode;
    logic [4:0]  o_source_reg;
    logic [4:0]  o_target_reg;
    logic [4:0]  o_dest_reg;
    logic [4:0]  o_shift_amount;
    logic [5:0]  o_function_code;
    logic [15:0] o_immediate;
    logic [25:0] o_jump_target;

    // Travels with the instruction word so the monitor sees both at the same edge
    bit          typed_valid = 1'b0;
    decoded_t    typed_decode = '0;

    decoded_t    pending_decodes[$];
    row_t        directed_rows[$];
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    int          n_items = 0;
    int          n_fmt_r = 0;
    int          n_fmt_i = 0;
    int          n_fmt_j = 0;
    int          n_fmt_bad = 0;
    int          n_unrec = 0;

    // Well-formed operations for the random part
    logic [5:0] r_functs [0:27] = '{
        FN_ADD, FN_ADDU, FN_AND, FN_DIV, FN_DIVU, FN_JALR, FN_JR, FN_MFHI, FN_MFLO,
        FN_MTHI, FN_MTLO, FN_MULT, FN_MULTU, FN_NOR, FN_OR, FN_SLL, FN_SLLV, FN_SLT,
        FN_SLTU, FN_SRA, FN_SRAV, FN_SRL, FN_SRLV, FN_SUB, FN_SUBU, FN_SYSCALL,
        FN_XOR, FN_BREAK
    };
    logic [5:0] i_opcodes [0:19] = '{
        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
        OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
        OP_SB, OP_SH, OP_SW
    };

    mips_instruction_decoder DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_instruction_word (i_instruction_word),
        .busy               (busy),
        .o_strobe           (o_strobe),
        .o_format           (o_format),
        .o_recognised       (o_recognised),
        .o_operation_id     (o_operation_id),
        .o_opcode           (o_opcode),
        .o_source_reg       (o_source_reg),
        .o_target_reg       (o_target_reg),
        .o_dest_reg         (o_dest_reg),
        .o_shift_amount     (o_shift_amount),
        .o_function_code    (o_function_code),
        .o_immediate        (o_immediate),
        .o_jump_target      (o_jump_target)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // R-format funct lookup; returns 0 for a funct with no operation
    function automatic bit funct_to_op(input logic [5:0] fn, output t_op_id id);
        bit hit;
        hit = 1'b1;
        id  = OPID_ADD;
        case (fn)
            FN_ADD:     id = OPID_ADD;
            FN_ADDU:    id = OPID_ADDU;
            FN_AND:     id = OPID_AND;
            FN_DIV:     id = OPID_DIV;
            FN_DIVU:    id = OPID_DIVU;
            FN_JALR:    id = OPID_JALR;
            FN_JR:      id = OPID_JR;
            FN_MFHI:    id = OPID_MFHI;
            FN_MFLO:    id = OPID_MFLO;
            FN_MTHI:    id = OPID_MTHI;
            FN_MTLO:    id = OPID_MTLO;
            FN_MULT:    id = OPID_MULT;
            FN_MULTU:   id = OPID_MULTU;
            FN_NOR:     id = OPID_NOR;
            FN_OR:      id = OPID_OR;
            FN_SLL:     id = OPID_SLL;
            FN_SLLV:    id = OPID_SLLV;
            FN_SLT:     id = OPID_SLT;
            FN_SLTU:    id = OPID_SLTU;
            FN_SRA:     id = OPID_SRA;
            FN_SRAV:    id = OPID_SRAV;
            FN_SRL:     id = OPID_SRL;
            FN_SRLV:    id = OPID_SRLV;
            FN_SUB:     id = OPID_SUB;
            FN_SUBU:    id = OPID_SUBU;
            FN_SYSCALL: id = OPID_SYSCALL;
            FN_XOR:     id = OPID_XOR;
            FN_BREAK:   id = OPID_BREAK;
            default:    hit = 1'b0;
        endcase
        return hit;
    endfunction

    // I-format opcode lookup; LB and LH are I format but carry no operation
    function automatic bit iop_to_op(input logic [5:0] op, output t_op_id id);
        bit hit;
        hit = 1'b1;
        id  = OPID_ADD;
        case (op)
            OP_ADDI:  id = OPID_ADDI;
            OP_ADDIU: id = OPID_ADDIU;
            OP_ANDI:  id = OPID_ANDI;
            OP_BEQ:   id = OPID_BEQ;
            OP_BGTZ:  id = OPID_BGTZ;
            OP_BLEZ:  id = OPID_BLEZ;
            OP_BNE:   id = OPID_BNE;
            OP_LBU:   id = OPID_LBU;
            OP_LHU:   id = OPID_LHU;
            OP_LUI:   id = OPID_LUI;
            OP_LW:    id = OPID_LW;
            OP_ORI:   id = OPID_ORI;
            OP_SB:    id = OPID_SB;
            OP_SH:    id = OPID_SH;
            OP_SLTI:  id = OPID_SLTI;
            OP_SLTIU: id = OPID_SLTIU;
            OP_SW:    id = OPID_SW;
            OP_XORI:  id = OPID_XORI;
            default:  hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic t_format format_of(input logic [5:0] op);
        case (op)
            OP_SPECIAL, OP_COP0, OP_COP1, OP_COP2: return FMT_R;
            OP_J, OP_JAL:                          return FMT_J;
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
            OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
            OP_SB, OP_SH, OP_SW:                   return FMT_I;
            default:                               return FMT_BAD;
        endcase
    endfunction

    // Expected decode of one instruction word; unused fields stay zero
    function automatic decoded_t decode_word(input logic [31:0] w);
        decoded_t d;
        t_op_id   id;
        d        = '0;
        d.opcode = w[31:26];
        d.fmt    = format_of(w[31:26]);
        d.op_id  = OPID_ADD;
        case (d.fmt)
            FMT_R: begin
                d.rs  = w[25:21];
                d.rt  = w[20:16];
                d.rd  = w[15:11];
                d.sh  = w[10:6];
                d.fn  = w[5:0];
                d.rec = funct_to_op(w[5:0], id);
                if (d.rec)
                    d.op_id = id;
            end
            FMT_I: begin
                d.rs  = w[25:21];
                d.rt  = w[20:16];
                d.imm = w[15:0];
                d.rec = iop_to_op(w[31:26], id);
                if (d.rec)
                    d.op_id = id;
            end
            FMT_J: begin
                d.tgt   = w[25:0];
                d.rec   = 1'b1;
                d.op_id = (w[31:26] == OP_J) ? OPID_J : OPID_JAL;
            end
            default: ;
        endcase
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    function automatic decoded_t mk(input t_format f, input logic rec, input t_op_id id,
                                    input logic [5:0] op, input logic [4:0] rs,
                                    input logic [4:0] rt, input logic [4:0] rd,
                                    input logic [4:0] sh, input logic [5:0] fn,
                                    input logic [15:0] imm, input logic [25:0] tgt);
        decoded_t d;
        d = '{f, rec, id, op, rs, rt, rd, sh, fn, imm, tgt};
        return d;
    endfunction

    task automatic add_row(input logic [31:0] w, input bit has, input decoded_t d);
        row_t r;
        r.word      = w;
        r.has_typed = has;
        r.typed     = d;
        directed_rows.push_back(r);
    endtask

    task automatic build_directed();
        // all zero is SLL r0, r0, 0
        add_row(32'h0000_0000, 1, mk(FMT_R, 1, OPID_SLL, OP_SPECIAL, 0, 0, 0, 0, 0, 0, 0));
        // all ones: opcode 0x3F is unlisted, only the opcode comes through
        add_row(32'hFFFF_FFFF, 1, mk(FMT_BAD, 0, OPID_ADD, 6'h3F, 0, 0, 0, 0, 0, 0, 0));
        add_row({6'h3F, 26'h0}, 1, mk(FMT_BAD, 0, OPID_ADD, 6'h3F, 0, 0, 0, 0, 0, 0, 0));
        // R format with unknown funct keeps its fields
        add_row({OP_SPECIAL, 26'h3FF_FFFF}, 1,
                mk(FMT_R, 0, OPID_ADD, OP_SPECIAL, 31, 31, 31, 31, 6'h3F, 0, 0));
        add_row({OP_COP2, 26'h3FF_FFFF}, 1,
                mk(FMT_R, 0, OPID_ADD, OP_COP2, 31, 31, 31, 31, 6'h3F, 0, 0));
        add_row({OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, 6'h01}, 0, '0);
        add_row({OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, FN_BREAK}, 0, '0);
        add_row({OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL}, 0, '0);
        add_row({OP_SPECIAL, 5'd31, 5'd0, 5'd31, 5'd0, FN_JALR}, 0, '0);
        // coprocessor opcodes go through the R funct table
        add_row({OP_COP0, 5'd1, 5'd2, 5'd3, 5'd4, FN_ADD}, 0, '0);
        add_row({OP_COP1, 5'd31, 5'd31, 5'd31, 5'd31, FN_SLTU}, 0, '0);
        // jumps with extreme targets
        add_row({OP_J, 26'h3FF_FFFF}, 1,
                mk(FMT_J, 1, OPID_J, OP_J, 0, 0, 0, 0, 0, 0, 26'h3FF_FFFF));
        add_row({OP_JAL, 26'h0}, 1, mk(FMT_J, 1, OPID_JAL, OP_JAL, 0, 0, 0, 0, 0, 0, 0));
        // LB and LH: I format, no operation
        add_row({OP_LB, 26'h3FF_FFFF}, 1,
                mk(FMT_I, 0, OPID_ADD, OP_LB, 31, 31, 0, 0, 0, 16'hFFFF, 0));
        add_row({OP_LH, 26'h0}, 1, mk(FMT_I, 0, OPID_ADD, OP_LH, 0, 0, 0, 0, 0, 0, 0));
        add_row({OP_LUI, 5'd0, 5'd31, 16'hFFFF}, 0, '0);
        add_row({OP_BEQ, 5'd31, 5'd31, 16'h8000}, 0, '0);
        add_row({OP_SW, 5'd29, 5'd31, 16'h7FFF}, 0, '0);
        add_row({OP_XORI, 5'd0, 5'd0, 16'h0001}, 0, '0);
        // LL, SC, LWL, LWR have ids but their opcodes are not decoded
        add_row({6'h30, 26'h3FF_FFFF}, 1,
                mk(FMT_BAD, 0, OPID_ADD, 6'h30, 0, 0, 0, 0, 0, 0, 0));
        add_row({6'h38, 26'h3FF_FFFF}, 1,
                mk(FMT_BAD, 0, OPID_ADD, 6'h38, 0, 0, 0, 0, 0, 0, 0));
        add_row({6'h22, 26'h155_5555}, 1,
                mk(FMT_BAD, 0, OPID_ADD, 6'h22, 0, 0, 0, 0, 0, 0, 0));
        add_row({6'h26, 26'h2AA_AAAA}, 1,
                mk(FMT_BAD, 0, OPID_ADD, 6'h26, 0, 0, 0, 0, 0, 0, 0));
        // REGIMM is unlisted here
        add_row({6'h01, 26'h3FF_FFFF}, 1,
                mk(FMT_BAD, 0, OPID_ADD, 6'h01, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)      return 0;
        else if (p < 85) return $urandom_range(1, 3);
        else if (p < 97) return $urandom_range(4, 12);
        else             return $urandom_range(20, 60);
    endfunction

    // Low 26 bits, with all-zero and all-ones now and then
    function automatic logic [25:0] rand_payload();
        int          p;
        logic [31:0] r;
        p = $urandom_range(0, 19);
        r = $urandom();
        if (p == 0)      return '0;
        else if (p == 1) return '1;
        else             return r[25:0];
    endfunction

    function automatic logic [31:0] random_word();
        int          p;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [25:0] pl;
        t_op_id      id;
        p  = $urandom_range(0, 99);
        pl = rand_payload();
        if (p < 35) begin
            // well-formed R operation, mostly SPECIAL, sometimes a coprocessor opcode
            case ($urandom_range(0, 9))
                7:       op = OP_COP0;
                8:       op = OP_COP1;
                9:       op = OP_COP2;
                default: op = OP_SPECIAL;
            endcase
            return {op, pl[25:6], r_functs[$urandom_range(0, 27)]};
        end else if (p < 67) begin
            return {i_opcodes[$urandom_range(0, 19)], pl};
        end else if (p < 77) begin
            return {($urandom_range(0, 1) != 0) ? OP_J : OP_JAL, pl};
        end else if (p < 85) begin
            // R format with a funct that names nothing
            do fn = $urandom_range(0, 63); while (funct_to_op(fn, id));
            return {OP_SPECIAL, pl[25:6], fn};
        end else if (p < 91) begin
            do op = $urandom_range(0, 63); while (format_of(op) != FMT_BAD);
            return {op, pl};
        end else begin
            return $urandom();
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    // Offer one word after an optional gap, hold it until it is taken
    task automatic offer_word(input logic [31:0] w, input bit has, input decoded_t d,
                              input int gap);
        if (gap > 0) begin
            start              <= 1'b0;
            i_instruction_word <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_instruction_word <= w;
        typed_valid        <= has;
        typed_decode       <= d;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Stop sending until every outstanding item has come back
    task automatic drain_outstanding();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_decodes.size() != 0);
    endtask

    initial begin : stimulus
        int burst_left;
        int gap;
        burst_left = 0;
        build_directed();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < directed_rows.size(); k++)
            offer_word(directed_rows[k].word, directed_rows[k].has_typed,
                       directed_rows[k].typed, pick_gap());

        // sender holds off until the pipeline is empty at least once
        drain_outstanding();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // back-to-back bursts, gapped stretches and the odd full drain
            if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end else begin
                gap = pick_gap();
                if ($urandom_range(0, 49) == 0)
                    burst_left = $urandom_range(20, 60);
            end
            if ($urandom_range(0, 99) == 0)
                drain_outstanding();
            offer_word(random_word(), 1'b0, '0, gap);
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending_decodes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Decoded %0d items: %0d R, %0d I, %0d J, %0d unlisted opcode, %0d unrecognised",
                 n_items, n_fmt_r, n_fmt_i, n_fmt_j, n_fmt_bad, n_unrec);
        $display("Directed extremes and odd opcodes, then random words with gaps and bursts");
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Accept first, then check, so a result given in the same cycle as its word would still find its item
    always @(posedge i_clk) begin : monitor
        decoded_t want;
        bit       active;
        if (i_rst_n) begin
            active = 1'b0;
            if (start && !busy) begin
                pending_decodes.push_back(typed_valid ? typed_decode
                                                      : decode_word(i_instruction_word));
                n_items++;
                active = 1'b1;
            end
            if (o_strobe === 1'b1) begin
                active = 1'b1;
                if (pending_decodes.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    mismatch_cnt++;
                end else begin
                    want = pending_decodes.pop_front();
                    check_field("format", want.fmt, o_format);
                    check_field("recognised", want.rec, o_recognised);
                    check_field("operation_id", want.op_id, o_operation_id);
                    check_field("opcode", want.opcode, o_opcode);
                    check_field("source_reg", want.rs, o_source_reg);
                    check_field("target_reg", want.rt, o_target_reg);
                    check_field("dest_reg", want.rd, o_dest_reg);
                    check_field("shift_amount", want.sh, o_shift_amount);
                    check_field("function_code", want.fn, o_function_code);
                    check_field("immediate", want.imm, o_immediate);
                    check_field("jump_target", want.tgt, o_jump_target);
                    case (want.fmt)
                        FMT_R:   n_fmt_r++;
                        FMT_I:   n_fmt_i++;
                        FMT_J:   n_fmt_j++;
                        default: n_fmt_bad++;
                    endcase
                    if (!want.rec)
                        n_unrec++;
                end
            end
            // watchdog: too long with neither side moving
            if (active)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without progress, %0d items outstanding",
                         idle_cycles, pending_decodes.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
